// ----- hw/rtl/lpht_pkg.sv -----
// Shared types, constants and codes for the linear probe hash table.
package lpht_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int QDEPTH   = 2;

    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_SET    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_LIVE  = 2'd1,
        KIND_TOMB  = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_RSVD   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        was_new_key;
        logic [63:0] read_value;
    } rsp_t;

    // Request as classified by the front end.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] key_id;
        logic [IDX_W-1:0] start;
        logic [63:0] new_value;
    } job_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE
    } eng_state_t;

endpackage

// ----- hw/rtl/lpht_front.sv -----
// Front end: accepts requests, computes the start slot and queues jobs.
module lpht_front (
    input  logic           clk,
    input  logic           rst_n,
    input  lpht_pkg::req_t req,
    input  logic           push,
    output logic           full,
    output lpht_pkg::job_t job,
    output logic           job_valid,
    input  logic           job_take
);
    import lpht_pkg::*;

    job_t q_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0]   cnt_reg;
    job_t in_job;
    logic wr, rd;

    // Classify the incoming request.
    always_comb
    begin
        in_job.mode      = mode_t'(req.mode);
        in_job.key_id    = req.key_id;
        in_job.start     = req.key_hash[IDX_W-1:0];
        in_job.new_value = req.new_value;
    end

    assign full      = (cnt_reg == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rp_reg];
    assign wr        = push && !full;
    assign rd        = job_take && job_valid;

    // Job queue storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= in_job;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{$clog2(QDEPTH){1'b0}}, wr} - {{$clog2(QDEPTH){1'b0}}, rd};
        end
    end

endmodule

// ----- hw/rtl/lpht_engine.sv -----
// Back end: walks the probe sequence through slot memories and updates them.
module lpht_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     load_limit,
    input  lpht_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_take,
    output lpht_pkg::rsp_t rsp,
    output logic           empty,
    input  logic           pop
);
    import lpht_pkg::*;

    // Slot memories; the kind memory is cleared by a pass after reset.
    kind_t       kind_mem [SLOTS];
    logic [31:0] key_mem [SLOTS];
    logic [63:0] val_mem [SLOTS];
    kind_t       kind_rd_reg;
    logic [31:0] key_rd_reg;
    logic [63:0] val_rd_reg;

    eng_state_t state_reg, state_next;
    job_t  job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next, tomb_idx_reg, tomb_idx_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic  tomb_seen_reg, tomb_seen_next;
    logic [CNT_W-1:0] steps_reg, steps_next, used_reg, used_next;
    rsp_t  rsp_reg, rsp_next;
    logic  rsp_valid_reg, rsp_valid_next;
    logic  found_reg, found_next, fresh_reg, fresh_next, has_reg, has_next;
    logic [IDX_W-1:0] tgt_reg, tgt_next;
    logic  mem_we;
    logic  kind_we;
    logic [IDX_W-1:0] kind_wa;
    kind_t kind_wd;
    logic  kind_live, kind_tomb;

    assign kind_live = (kind_rd_reg == KIND_LIVE);
    assign kind_tomb = (kind_rd_reg == KIND_TOMB);
    assign rsp   = rsp_reg;
    assign empty = !rsp_valid_reg;

    // Registered kind/key/value read at the probe index.
    always_ff @(posedge clk)
    begin
        kind_rd_reg <= kind_mem[idx_reg];
        key_rd_reg  <= key_mem[idx_reg];
        val_rd_reg  <= val_mem[idx_reg];
        if (kind_we)
        begin
            kind_mem[kind_wa] <= kind_wd;
        end
        if (mem_we)
        begin
            key_mem[tgt_reg] <= job_reg.key_id;
            val_mem[tgt_reg] <= job_reg.new_value;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        tomb_idx_next  = tomb_idx_reg;
        tomb_seen_next = tomb_seen_reg;
        steps_next     = steps_reg;
        used_next      = used_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !pop;
        found_next     = found_reg;
        fresh_next     = fresh_reg;
        has_next       = has_reg;
        tgt_next       = tgt_reg;
        clr_next       = clr_reg;
        job_take       = 1'b0;
        mem_we         = 1'b0;
        kind_we        = 1'b0;
        kind_wa        = tgt_reg;
        kind_wd        = KIND_EMPTY;
        unique case (state_reg)
            S_CLEAR:
            begin
                // Empty one slot per cycle after reset.
                kind_we  = 1'b1;
                kind_wa  = clr_reg;
                kind_wd  = KIND_EMPTY;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_take       = 1'b1;
                    job_next       = job;
                    idx_next       = job.start;
                    tomb_seen_next = 1'b0;
                    steps_next     = '0;
                    found_next     = 1'b0;
                    fresh_next     = 1'b0;
                    has_next       = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                // Memory read in flight for idx_reg.
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!kind_live && !kind_tomb)
                begin
                    has_next   = 1'b1;
                    tgt_next   = tomb_seen_reg ? tomb_idx_reg : idx_reg;
                    fresh_next = !tomb_seen_reg;
                    state_next = S_WRITE;
                end
                else if (kind_live && key_rd_reg == job_reg.key_id)
                begin
                    has_next   = 1'b1;
                    found_next = 1'b1;
                    tgt_next   = idx_reg;
                    state_next = S_WRITE;
                end
                else
                begin
                    if (kind_tomb && !tomb_seen_reg)
                    begin
                        tomb_seen_next = 1'b1;
                        tomb_idx_next  = idx_reg;
                    end
                    idx_next   = idx_reg + 1'b1;
                    steps_next = steps_reg + 1'b1;
                    if (steps_reg == CNT_W'(SLOTS - 1))
                    begin
                        has_next   = tomb_seen_reg || kind_tomb;
                        tgt_next   = tomb_seen_reg ? tomb_idx_reg : idx_reg;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_WRITE:
            begin
                // Wait for the result register to free up.
                if (!rsp_valid_reg || pop)
                begin
                    rsp_next.status      = ST_ABSENT;
                    rsp_next.was_new_key = 1'b0;
                    rsp_next.read_value  = '0;
                    case (job_reg.mode)
                        MODE_GET:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.status     = ST_OK;
                                rsp_next.read_value = val_rd_reg;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.status = ST_OK;
                                kind_we         = 1'b1;
                                kind_wd         = KIND_TOMB;
                            end
                        end
                        MODE_SET:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.status = ST_OK;
                                mem_we          = 1'b1;
                            end
                            else if (!has_reg || (fresh_reg &&
                                     (used_reg + 1'b1) > {1'b0, load_limit}))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                rsp_next.status      = ST_OK;
                                rsp_next.was_new_key = 1'b1;
                                mem_we               = 1'b1;
                                kind_we              = 1'b1;
                                kind_wd              = KIND_LIVE;
                                if (fresh_reg && used_reg < CNT_W'(SLOTS))
                                begin
                                    used_next = used_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_valid_next = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        idx_reg       <= idx_next;
        tomb_idx_reg  <= tomb_idx_next;
        tomb_seen_reg <= tomb_seen_next;
        steps_reg     <= steps_next;
        rsp_reg       <= rsp_next;
        found_reg     <= found_next;
        fresh_reg     <= fresh_next;
        has_reg       <= has_next;
        tgt_reg       <= tgt_next;
    end

endmodule

// ----- hw/rtl/linear_probe_hash_table_top.sv -----
// Top level of the linear probe hash table.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------
//  request | push / full         | req (req_t)
//  result  | pop / empty         | rsp (rsp_t)
//  config  | cfg_valid/cfg_ready | cfg_data (load_limit)
//
// In the engine a request takes the job in S_IDLE, then reads and compares each of the P slots
// probed (at most 256) in S_READ and S_CHECK, then passes a write step (S_WRITE) and a closing
// step (S_DONE).
// The front queue holds two requests, so input continues while the engine works.
// After reset the engine clears the kinds of all 256 slots, one slot per cycle.
// A result held in the output register stalls only the engine's write step.
module linear_probe_hash_table_top (
    input  logic           clk,
    input  logic           rst_n,
    input  lpht_pkg::req_t req,
    input  logic           push,
    output logic           full,
    output lpht_pkg::rsp_t rsp,
    output logic           empty,
    input  logic           pop,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data
);
    import lpht_pkg::*;

    job_t job;
    logic job_valid, job_take;
    logic [7:0] limit_reg;

    assign cfg_ready = 1'b1;

    // Load limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 8'd192;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    lpht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .push      (push),
        .full      (full),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take)
    );

    lpht_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_limit (limit_reg),
        .job        (job),
        .job_valid  (job_valid),
        .job_take   (job_take),
        .rsp        (rsp),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ----- hw/rtl/lpht_checker.sv -----
// Port-level checks for the hash table, bound to the top level.
module lpht_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pop,
    input logic           empty,
    input lpht_pkg::rsp_t rsp
);
    import lpht_pkg::*;

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("result changed while waiting");

    // Status is never the reserved code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rsp.status != ST_RSVD))
        else $error("reserved status");

    // Only a successful status reports a new key.
    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.was_new_key) |-> (rsp.status == ST_OK && rsp.read_value == '0))
        else $error("bad new key flag");

    // Absent or full results carry a zero value.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status != ST_OK) |-> (rsp.read_value == '0 && !rsp.was_new_key))
        else $error("nonzero fields on failure");

    // Results come only after requests: empty right after reset.
    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result after reset");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .pop   (pop),
    .empty (empty),
    .rsp   (rsp)
);
